>>> rtl/bdnf_pkg.sv
// Shared constants, types and byte helper for the byte-distance novelty filter.
package bdnf_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int GENOME_BYTES = 16;
    localparam int HALF_W       = 64;
    localparam int GENOME_W     = 2 * HALF_W;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int TOTAL_W      = 7;
    localparam int DIST_W       = 5;

    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(4);

    // Result of the merging stage for one stored entry.
    typedef struct packed {
        logic valid;
        logic near;
    } t_near;

    // Byte k of a genome held as {high half, low half}.
    function automatic logic [7:0] genome_byte(input logic [GENOME_W-1:0] g, input int k);
        genome_byte = g[k*8 +: 8];
    endfunction

endpackage

>>> rtl/bdnf_store.sv
// Genome store: one write port, one read port with registered read data.
module bdnf_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [bdnf_pkg::IDX_W-1:0]    i_waddr,
    input  logic [bdnf_pkg::GENOME_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [bdnf_pkg::IDX_W-1:0]    i_raddr,
    output logic [bdnf_pkg::GENOME_W-1:0] o_rdata,
    output logic                          o_rvalid
);

    logic [bdnf_pkg::GENOME_W-1:0] r_mem [bdnf_pkg::MAX_ENTRIES];
    logic [bdnf_pkg::GENOME_W-1:0] r_rdata;
    logic                          r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_re;
        end
    end

    assign o_rdata  = r_rdata;
    assign o_rvalid = r_rvalid;

endmodule

>>> rtl/bdnf_lane.sv
// One comparison lane: flags a byte of the query that differs from the stored byte.
module bdnf_lane (
    input  logic [7:0] i_query_byte,
    input  logic [7:0] i_entry_byte,
    output logic       o_differs
);

    assign o_differs = (i_query_byte != i_entry_byte);

endmodule

>>> rtl/bdnf_merge.sv
// Merging stage: counts differing bytes over all lanes and flags entries that are too close.
module bdnf_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bdnf_pkg::GENOME_BYTES-1:0] i_diff,
    input  logic                              i_valid,
    input  logic [bdnf_pkg::DIST_W-1:0]       i_min_distance,
    output bdnf_pkg::t_near                   o_res
);

    logic [bdnf_pkg::DIST_W-1:0] diff_count;
    logic                        r_valid;
    logic                        r_near;

    assign diff_count = bdnf_pkg::DIST_W'($countones(i_diff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_near <= (diff_count < i_min_distance);
    end

    assign o_res.valid = r_valid;
    assign o_res.near  = r_near;

endmodule

>>> rtl/byte_distance_novelty_filter_top.sv
// Top level of the byte-distance novelty filter: control, lanes, store and result register.
//
//  channel   direction  handshake                    payload
//  request   in         i_valid / o_ready            i_genome_low, i_genome_high, i_commit
//  result    out        o_valid / i_ready            o_novel, o_stored, o_entry_total
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_min_distance
//
// From acceptance, a request scans the store: the store's single read port
// delivers one stored entry per cycle, each passing through the read register
// and the merging stage; once both are empty the decision is registered and
// the result is then loaded into the result register. With an empty store no
// read is issued and the decision is made directly, without any store read.
// Reset is synchronous, active low; it empties the store (count to zero) and
// sets min_distance to 4. The store contents are not cleared.
// A stalled result waits in the output register; the next request is taken
// once that result has moved into the output register.
module byte_distance_novelty_filter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bdnf_pkg::HALF_W-1:0] i_genome_low,
    input  logic [bdnf_pkg::HALF_W-1:0] i_genome_high,
    input  logic                        i_commit,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_novel,
    output logic                        o_stored,
    output logic [bdnf_pkg::TOTAL_W-1:0] o_entry_total,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bdnf_pkg::DIST_W-1:0] i_cfg_min_distance
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                              r_state;
    logic [bdnf_pkg::HALF_W-1:0]         r_lo;
    logic [bdnf_pkg::HALF_W-1:0]         r_hi;
    logic                                r_commit;
    logic [bdnf_pkg::CNT_W-1:0]          r_count;
    logic [bdnf_pkg::CNT_W-1:0]          r_idx;
    logic                                r_far;
    logic                                r_novel;
    logic                                r_stored;
    logic                                r_out_valid;
    logic                                r_out_novel;
    logic                                r_out_stored;
    logic [bdnf_pkg::CNT_W-1:0]          r_out_total;
    logic [bdnf_pkg::DIST_W-1:0]         r_min_dist;

    logic [bdnf_pkg::GENOME_W-1:0]       query;
    logic [bdnf_pkg::GENOME_W-1:0]       rd_data;
    logic                                rd_valid;
    logic                                rd_issue;
    logic                                scan_done;
    logic                                novel_now;
    logic                                we;
    logic                                out_load;
    logic [bdnf_pkg::GENOME_BYTES-1:0]   diff;
    bdnf_pkg::t_near                     mrg;

    assign query = {r_hi, r_lo};

    // Issue one stored entry per cycle until the count is reached.
    assign rd_issue  = (r_state == S_SCAN) && (r_idx < r_count);
    // Everything issued and both pipeline stages empty: verdict is final.
    assign scan_done = (r_state == S_SCAN) && (r_idx == r_count) && !rd_valid && !mrg.valid;
    assign novel_now = r_far && (r_count < bdnf_pkg::CNT_W'(bdnf_pkg::MAX_ENTRIES));
    assign we        = scan_done && r_commit && novel_now;
    // Load the output register once it is free or being emptied this cycle.
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_ready);

    bdnf_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (r_count[bdnf_pkg::IDX_W-1:0]),
        .i_wdata (query),
        .i_re    (rd_issue),
        .i_raddr (r_idx[bdnf_pkg::IDX_W-1:0]),
        .o_rdata (rd_data),
        .o_rvalid(rd_valid)
    );

    // One lane per compared byte; all GENOME_BYTES bytes of the genome are compared.
    for (genvar k = 0; k < bdnf_pkg::GENOME_BYTES; k++) begin : g_lane
        bdnf_lane u_lane (
            .i_query_byte(bdnf_pkg::genome_byte(query, k)),
            .i_entry_byte(bdnf_pkg::genome_byte(rd_data, k)),
            .o_differs   (diff[k])
        );
    end

    bdnf_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_diff        (diff),
        .i_valid       (rd_valid),
        .i_min_distance(r_min_dist),
        .o_res         (mrg)
    );

    // Sequencer: capture request, scan store, decide, hand result to output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_far       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // load a waiting result, or drop the one on the port once taken
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_novel  <= r_novel;
                r_out_stored <= r_stored;
                r_out_total  <= r_count;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_lo     <= i_genome_low;
                        r_hi     <= i_genome_high;
                        r_commit <= i_commit;
                        r_idx    <= '0;
                        r_far    <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_issue) begin
                        r_idx <= bdnf_pkg::CNT_W'(r_idx + 1'b1);
                    end
                    if (mrg.valid && mrg.near) begin
                        r_far <= 1'b0;
                    end
                    if (scan_done) begin
                        r_novel  <= novel_now;
                        r_stored <= we;
                        if (we) begin
                            r_count <= bdnf_pkg::CNT_W'(r_count + 1'b1);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Config register; the user writes it only while no request is in flight; unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= bdnf_pkg::MIN_DIST_RESET;
        end else if (i_cfg_valid) begin
            r_min_dist <= i_cfg_min_distance;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_novel       = r_out_novel;
    assign o_stored      = r_out_stored;
    assign o_entry_total = bdnf_pkg::TOTAL_W'(r_out_total);
    assign o_cfg_ready   = 1'b1;

    // The store never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdnf_pkg::CNT_W'(bdnf_pkg::MAX_ENTRIES))
        else $error("entry count beyond store depth");

    // A write to the store raises the count by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> (r_count == bdnf_pkg::CNT_W'($past(r_count) + 1'b1)))
        else $error("entry count did not follow a store write");

    // No write while a read of the same scan is still in flight.
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (!rd_valid && !mrg.valid && !rd_issue))
        else $error("store written during a scan");

    // A stored genome was always reported novel.
    a_stored_novel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_stored || o_novel))
        else $error("stored result without novelty");

endmodule
